@@ src/prs_pkg.sv @@
// Shared types and constants for the polynomial reduce and solve block.
package prs_pkg;

	localparam int SUM_W = 48;
	localparam int VAL_W = 32;

	typedef enum logic [2:0] {
		ST_ALL_X = 3'd0,
		ST_CONTRA = 3'd1,
		ST_LINEAR = 3'd2,
		ST_TWO_REAL = 3'd3,
		ST_DOUBLE = 3'd4,
		ST_COMPLEX = 3'd5,
		ST_HIGH_DEG = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_ACC,
		S_SCAN,
		S_MUL_P,
		S_MUL_P_W,
		S_MUL_Q,
		S_MUL_Q_W,
		S_DISC,
		S_SQRT_SET,
		S_SQRT,
		S_DIV1_SET,
		S_DIV1,
		S_DIV2_SET,
		S_DIV2,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_DIV,
		OP_SQRT,
		OP_MUL
	} unit_op_t;

	// Start and completion between the sequencer and the shared unit.
	typedef struct packed {
		logic start_div;
		logic start_sqrt;
		logic start_mul;
	} unit_cmd_t;

	typedef struct packed {
		logic done;
	} unit_sts_t;

endpackage

@@ src/polynomial_reduce_and_solve.sv @@
// Top level: term accumulation, degree scan and solve sequencer.
//
// Terms enter on the s_axis group, one transfer per cycle while no equation
// is being solved. Each transfer adds or subtracts its coefficient into the
// 48-bit saturating sum for its exponent. A transfer with tlast set starts
// solving: the sums are scanned; for a quadratic the shared unit then forms
// b*b and a*c with two 64-step shift-add multiplies and, unless the
// discriminant is zero, runs a 51-step square root; then up to two 128-step
// divisions follow. s_axis_tready is low from the last term until the result
// transfer on m_axis.
// The result is held on m_axis until m_axis_tready; then sums and the
// overflow flag are cleared and terms are taken again.
// Reset clears all sums, the overflow flag and the sequencer.
module polynomial_reduce_and_solve #(
	parameter int MAX_DEGREE = 7,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata, // coefficient[31:0], exponent[34:32], right_side[35]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata // status[2:0], degree[5:3], first_value[37:6], second_value[69:38], overflow[70]
);
	localparam int NS = MAX_DEGREE + 1;
	localparam int IW = $clog2(NS + 1);
	localparam int EW = $clog2(NS);
	localparam logic signed [47:0] SMAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] SMIN = 48'sh8000_0000_0000;

	prs_pkg::state_t state_q, state_d;
	logic signed [47:0] sums_q [NS];
	logic sum_ovf_q;
	logic ovf_q;
	logic [IW-1:0] idx_q;
	logic [3:0] deg_q;
	logic signed [47:0] a_q, b_q, c_q;
	logic [127:0] p_q, qv_q, d_q;
	logic dneg_q;
	logic [63:0] sroot_q;
	logic [31:0] v1_q, v2_q;
	prs_pkg::status_t status_q;
	logic [1:0] pass_q;

	logic acc;
	logic signed [31:0] coef;
	logic [2:0] expn;
	logic signed [49:0] s_ext;
	logic [47:0] ma, mb, mc;
	logic sa;
	logic [63:0] num_mag, den_mag;
	logic num_neg;
	logic [63:0] ures;
	logic [127:0] uprod;
	prs_pkg::unit_cmd_t cmd;
	prs_pkg::unit_sts_t usts;
	logic [31:0] sat_val;
	logic sat_ovf;
	logic signed [64:0] nsig;

	assign coef = s_axis_tdata[31:0];
	assign expn = s_axis_tdata[34:32];
	assign s_axis_tready = (state_q == prs_pkg::S_ACC);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == prs_pkg::S_OUT);
	assign m_axis_tdata = {1'b0, ovf_q, v2_q, v1_q, deg_q[2:0], status_q};

	function automatic logic [47:0] mag48(input logic signed [47:0] x);
		return x[47] ? 48'(-x) : 48'(x);
	endfunction

	always_comb begin
		ma = mag48(a_q);
		mb = mag48(b_q);
		mc = mag48(c_q);
		sa = a_q[47];
		s_ext = (32'(expn) < NS) ? 50'(sums_q[EW'(expn)]) : '0;
		s_ext = s_axis_tdata[35] ? s_ext - 50'(coef) : s_ext + 50'(coef);
		// numerator for the current division
		nsig = '0;
		num_neg = 1'b0;
		num_mag = '0;
		den_mag = {15'd0, ma, 1'b0};
		if (deg_q == 4'd1) begin
			nsig = -65'(c_q);
			den_mag = {16'd0, mb};
			num_neg = nsig[64] ^ b_q[47];
		end else if (status_q == prs_pkg::ST_TWO_REAL) begin
			nsig = (pass_q == 2'd0) ? -65'(b_q) + 65'(sroot_q) : -65'(b_q) - 65'(sroot_q);
			num_neg = nsig[64] ^ sa;
		end else if (status_q == prs_pkg::ST_COMPLEX && pass_q == 2'd1) begin
			nsig = 65'(sroot_q);
			num_neg = 1'b0;
		end else begin
			nsig = -65'(b_q);
			num_neg = nsig[64] ^ sa;
		end
		num_mag = nsig[64] ? 64'(-nsig) : 64'(nsig);
		// operands for the discriminant products
		if (state_q == prs_pkg::S_MUL_P) begin
			num_mag = {16'd0, mb};
			den_mag = {16'd0, mb};
		end else if (state_q == prs_pkg::S_MUL_Q) begin
			num_mag = {16'd0, ma};
			den_mag = {16'd0, mc};
		end
		sat_ovf = 1'b0;
		if (!num_neg) begin
			if (ures > 64'h7FFF_FFFF) begin
				sat_val = 32'h7FFF_FFFF;
				sat_ovf = 1'b1;
			end else begin
				sat_val = ures[31:0];
			end
		end else begin
			if (ures > 64'h8000_0000) begin
				sat_val = 32'h8000_0000;
				sat_ovf = 1'b1;
			end else begin
				sat_val = 32'(-ures);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prs_pkg::S_ACC: if (acc && s_axis_tlast) state_d = prs_pkg::S_SCAN;
			prs_pkg::S_SCAN: if (idx_q == IW'(NS)) begin
				if (deg_q == 4'd1) state_d = prs_pkg::S_DIV1_SET;
				else if (deg_q == 4'd2) state_d = prs_pkg::S_MUL_P;
				else state_d = prs_pkg::S_OUT;
			end
			prs_pkg::S_MUL_P: state_d = prs_pkg::S_MUL_P_W;
			prs_pkg::S_MUL_P_W: if (usts.done) state_d = prs_pkg::S_MUL_Q;
			prs_pkg::S_MUL_Q: state_d = prs_pkg::S_MUL_Q_W;
			prs_pkg::S_MUL_Q_W: if (usts.done) state_d = prs_pkg::S_DISC;
			prs_pkg::S_DISC: state_d = prs_pkg::S_SQRT_SET;
			prs_pkg::S_SQRT_SET: begin
				if (d_q == '0) state_d = prs_pkg::S_DIV1_SET;
				else state_d = prs_pkg::S_SQRT;
			end
			prs_pkg::S_SQRT: if (usts.done) state_d = prs_pkg::S_DIV1_SET;
			prs_pkg::S_DIV1_SET: state_d = prs_pkg::S_DIV1;
			prs_pkg::S_DIV1: if (usts.done) begin
				if (deg_q == 4'd2 && status_q != prs_pkg::ST_DOUBLE)
					state_d = prs_pkg::S_DIV2_SET;
				else state_d = prs_pkg::S_OUT;
			end
			prs_pkg::S_DIV2_SET: state_d = prs_pkg::S_DIV2;
			prs_pkg::S_DIV2: if (usts.done) state_d = prs_pkg::S_OUT;
			prs_pkg::S_OUT: if (m_axis_tready) state_d = prs_pkg::S_ACC;
			default: state_d = prs_pkg::S_ACC;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			prs_pkg::S_MUL_P, prs_pkg::S_MUL_Q: cmd.start_mul = 1'b1;
			prs_pkg::S_SQRT_SET: cmd.start_sqrt = (d_q != '0);
			prs_pkg::S_DIV1_SET, prs_pkg::S_DIV2_SET: cmd.start_div = 1'b1;
			default: begin
			end
		endcase
	end

	prs_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .num(num_mag), .den(den_mag),
		.rad(d_q), .sts(usts), .res(ures), .prod(uprod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prs_pkg::S_ACC;
			sum_ovf_q <= 1'b0;
			for (int i = 0; i < NS; i++) sums_q[i] <= '0;
			idx_q <= '0;
			deg_q <= '0;
			pass_q <= '0;
		end else begin
			state_q <= state_d;
			if (acc && 32'(expn) < NS) begin
				if (s_ext > 50'(SMAX)) begin
					sums_q[EW'(expn)] <= SMAX;
					sum_ovf_q <= 1'b1;
				end else if (s_ext < 50'(SMIN)) begin
					sums_q[EW'(expn)] <= SMIN;
					sum_ovf_q <= 1'b1;
				end else begin
					sums_q[EW'(expn)] <= s_ext[47:0];
				end
			end
			if (state_q == prs_pkg::S_ACC) begin
				idx_q <= '0;
				deg_q <= '0;
				pass_q <= '0;
			end
			if (state_q == prs_pkg::S_SCAN && idx_q != IW'(NS)) begin
				if (idx_q != '0 && sums_q[idx_q[EW-1:0]] != '0) deg_q <= 4'(idx_q);
				idx_q <= idx_q + IW'(1);
			end
			if (state_q == prs_pkg::S_DIV1 && usts.done) pass_q <= 2'd1;
			if (state_q == prs_pkg::S_OUT && m_axis_tready) begin
				for (int i = 0; i < NS; i++) sums_q[i] <= '0;
				sum_ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == prs_pkg::S_SCAN && idx_q == IW'(NS)) begin
			a_q <= sums_q[2];
			b_q <= sums_q[1];
			c_q <= sums_q[0];
			ovf_q <= sum_ovf_q;
			v1_q <= '0;
			v2_q <= '0;
			if (deg_q > 4'd2) status_q <= prs_pkg::ST_HIGH_DEG;
			else if (deg_q == 4'd2) status_q <= prs_pkg::ST_TWO_REAL;
			else if (deg_q == 4'd1) status_q <= prs_pkg::ST_LINEAR;
			else if (sums_q[0] == '0) status_q <= prs_pkg::ST_ALL_X;
			else status_q <= prs_pkg::ST_CONTRA;
		end
		if (state_q == prs_pkg::S_MUL_P_W && usts.done) p_q <= uprod;
		if (state_q == prs_pkg::S_MUL_Q_W && usts.done) qv_q <= uprod << 2;
		if (state_q == prs_pkg::S_DISC) begin
			if (sa != c_q[47]) begin
				d_q <= p_q + qv_q;
				dneg_q <= 1'b0;
			end else if (p_q >= qv_q) begin
				d_q <= p_q - qv_q;
				dneg_q <= 1'b0;
			end else begin
				d_q <= qv_q - p_q;
				dneg_q <= 1'b1;
			end
		end
		if (state_q == prs_pkg::S_SQRT_SET) begin
			if (d_q == '0) status_q <= prs_pkg::ST_DOUBLE;
			else if (dneg_q) status_q <= prs_pkg::ST_COMPLEX;
		end
		if (state_q == prs_pkg::S_SQRT && usts.done) sroot_q <= ures;
		if ((state_q == prs_pkg::S_DIV1 || state_q == prs_pkg::S_DIV2) && usts.done) begin
			if (sat_ovf) ovf_q <= 1'b1;
			if (state_q == prs_pkg::S_DIV1) begin
				v1_q <= sat_val;
				if (status_q == prs_pkg::ST_DOUBLE) v2_q <= sat_val;
			end else begin
				v2_q <= sat_val;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) |=> !sum_ovf_q) else $error("flag not cleared");
`endif
endmodule

@@ src/prs_unit.sv @@
// Shared iterative unit: restoring division, floor square root and shift-add multiply.
module prs_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prs_pkg::unit_cmd_t  cmd,
	input  logic [63:0]         num,
	input  logic [63:0]         den,
	input  logic [127:0]        rad,
	output prs_pkg::unit_sts_t  sts,
	output logic [63:0]         res,
	output logic [127:0]        prod
);
	localparam int DIV_STEPS = 128;
	localparam int SQ_STEPS = 51;
	localparam int MUL_STEPS = 64;
	localparam int SQ_ALIGN = 128 - 2 * SQ_STEPS;
	localparam logic [63:0] QUOT_CAP = 64'd1 << 40;

	logic         busy_q;
	prs_pkg::unit_op_t op_q;
	logic [7:0]   cnt_q;
	logic [127:0] n_q;
	logic [63:0]  rem_q;
	logic [63:0]  q_q;
	logic [63:0]  den_q;

	logic [64:0]  rem_sh;
	logic [64:0]  rem_sub;
	logic [63:0]  sq_sh;
	logic [63:0]  sq_trial;
	logic [64:0]  sq_sub;

	always_comb begin
		rem_sh = {rem_q, n_q[127]};
		rem_sub = rem_sh - {1'b0, den_q};
		sq_sh = {rem_q[61:0], n_q[127:126]};
		sq_trial = {q_q[61:0], 2'b01};
		sq_sub = {1'b0, sq_sh} - {1'b0, sq_trial};
	end

	assign res = q_q;
	assign prod = n_q;
	assign sts.done = busy_q && (cnt_q == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			op_q <= prs_pkg::OP_DIV;
		end else if (cmd.start_div) begin
			busy_q <= 1'b1;
			op_q <= prs_pkg::OP_DIV;
			cnt_q <= 8'(DIV_STEPS);
		end else if (cmd.start_sqrt) begin
			busy_q <= 1'b1;
			op_q <= prs_pkg::OP_SQRT;
			cnt_q <= 8'(SQ_STEPS);
		end else if (cmd.start_mul) begin
			busy_q <= 1'b1;
			op_q <= prs_pkg::OP_MUL;
			cnt_q <= 8'(MUL_STEPS);
		end else if (busy_q) begin
			if (cnt_q == 8'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			n_q <= {64'd0, num} << FRAC_BITS;
			den_q <= den;
			rem_q <= '0;
			q_q <= (den == 64'd0) ? QUOT_CAP : 64'd0;
		end else if (cmd.start_sqrt) begin
			n_q <= rad << SQ_ALIGN;
			rem_q <= '0;
			q_q <= '0;
		end else if (cmd.start_mul) begin
			n_q <= '0;
			den_q <= num;
			q_q <= den;
		end else if (busy_q && cnt_q != 8'd0) begin
			unique case (op_q)
				prs_pkg::OP_DIV: if (den_q != 64'd0) begin
					n_q <= n_q << 1;
					if (!rem_sub[64]) begin
						rem_q <= rem_sub[63:0];
					end else begin
						rem_q <= rem_sh[63:0];
					end
					if (q_q < QUOT_CAP) begin
						q_q <= {q_q[62:0], ~rem_sub[64]};
					end
				end
				prs_pkg::OP_SQRT: begin
					n_q <= n_q << 2;
					if (!sq_sub[64]) begin
						rem_q <= sq_sub[63:0];
						q_q <= {q_q[62:0], 1'b1};
					end else begin
						rem_q <= sq_sh;
						q_q <= {q_q[62:0], 1'b0};
					end
				end
				prs_pkg::OP_MUL: begin
					n_q <= (n_q << 1) + (q_q[63] ? {64'd0, den_q} : 128'd0);
					q_q <= q_q << 1;
				end
				default: begin
				end
			endcase
		end
	end
endmodule

@@ tb/polynomial_reduce_and_solve_tb.sv @@
// Testbench for the polynomial reduce and solve block: directed and random equations checked against a predictor.
module polynomial_reduce_and_solve_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] coef;
		logic [2:0]  expo;
		bit          rs;
		bit          last;
	} term_t;

	typedef struct {
		prs_pkg::status_t status;
		logic [2:0]  degree;
		logic [31:0] v1;
		logic [31:0] v2;
		bit          ovf;
	} solution_t;

	localparam longint SUM_HI = 64'sh7FFFFFFFFFFF;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam logic [63:0] QCAP = 64'd1 << 40;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;

	term_t     pending[$];
	solution_t solutions[$];
	term_t     held;
	longint    sums[8];
	bit        sum_ovf;
	int        errors = 0;
	int        results_seen = 0;
	int        src_gap;
	int        dst_gap;
	int        hold_cnt;
	bit        hold_done;
	longint    cycles = 0;

	polynomial_reduce_and_solve dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] mag_of(longint x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [127:0] d);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int i = 50; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if ({64'd0, t} * {64'd0, t} <= d) r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] fix_div(logic [63:0] num, logic [63:0] den);
		logic [127:0] n;
		logic [127:0] q;
		if (den == 0) return QCAP;
		n = {64'd0, num} << 16;
		q = n / {64'd0, den};
		return (q >= {64'd0, QCAP}) ? QCAP : q[63:0];
	endfunction

	// bit 32 flags saturation
	function automatic logic [32:0] to_fixed(bit neg, logic [63:0] mag);
		if (!neg) begin
			if (mag > 64'h7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
			return {1'b0, mag[31:0]};
		end
		if (mag > 64'h80000000) return {1'b1, 32'h80000000};
		return {1'b0, 32'(0 - mag[31:0])};
	endfunction

	function automatic logic [32:0] signed_quot(longint num, logic [63:0] den, bit den_neg);
		return to_fixed((num < 0) != den_neg, fix_div(mag_of(num), den));
	endfunction

	task automatic solve_term(term_t t);
		longint    coef;
		longint    s;
		longint    a, b, c, nb, sq;
		logic [63:0]  ma, den;
		logic [127:0] p, q, d;
		logic [32:0]  r1, r2;
		bit        sa, dneg;
		int        k;
		solution_t res;
		coef = longint'($signed(t.coef));
		s = t.rs ? sums[t.expo] - coef : sums[t.expo] + coef;
		if (s > SUM_HI) begin s = SUM_HI; sum_ovf = 1; end
		if (s < SUM_LO) begin s = SUM_LO; sum_ovf = 1; end
		sums[t.expo] = s;
		if (!t.last) return;
		res.ovf = sum_ovf;
		res.v1 = 0;
		res.v2 = 0;
		r1 = 0;
		r2 = 0;
		for (k = 7; k > 0; k--)
			if (sums[k] != 0) break;
		res.degree = k[2:0];
		if (k > 2) begin
			res.status = prs_pkg::ST_HIGH_DEG;
		end else if (k == 0) begin
			res.status = (sums[0] == 0) ? prs_pkg::ST_ALL_X : prs_pkg::ST_CONTRA;
		end else if (k == 1) begin
			res.status = prs_pkg::ST_LINEAR;
			r1 = signed_quot(-sums[0], mag_of(sums[1]), sums[1] < 0);
		end else begin
			a = sums[2];
			b = sums[1];
			c = sums[0];
			nb = -b;
			ma = mag_of(a);
			den = ma << 1;
			sa = a < 0;
			p = {64'd0, mag_of(b)} * {64'd0, mag_of(b)};
			q = ({64'd0, ma} * {64'd0, mag_of(c)}) << 2;
			dneg = 0;
			if (sa != (c < 0)) d = p + q;
			else if (p >= q) d = p - q;
			else begin d = q - p; dneg = 1; end
			if (d == 0) begin
				res.status = prs_pkg::ST_DOUBLE;
				r1 = signed_quot(nb, den, sa);
				r2 = r1;
			end else if (!dneg) begin
				res.status = prs_pkg::ST_TWO_REAL;
				sq = longint'(floor_sqrt(d));
				r1 = signed_quot(nb + sq, den, sa);
				r2 = signed_quot(nb - sq, den, sa);
			end else begin
				res.status = prs_pkg::ST_COMPLEX;
				r1 = signed_quot(nb, den, sa);
				r2 = to_fixed(0, fix_div(floor_sqrt(d), den));
			end
		end
		res.v1 = r1[31:0];
		res.v2 = r2[31:0];
		res.ovf = res.ovf | r1[32] | r2[32];
		solutions.insert(solutions.size(), res);
		foreach (sums[i]) sums[i] = 0;
		sum_ovf = 0;
	endtask

	task automatic add_term(logic [31:0] coef, logic [2:0] expo, bit rs, bit last);
		term_t t;
		t.coef = coef;
		t.expo = expo;
		t.rs = rs;
		t.last = last;
		pending.insert(pending.size(), t);
	endtask

	function automatic logic [31:0] pick_coef();
		int v;
		case ($urandom_range(0, 5))
			0, 1: begin
				v = $urandom_range(0, 40) - 20;
				return 32'(v) << 16;
			end
			2: return $urandom;
			3: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
			4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'(int'($urandom_range(0, 2000)) - 1000) << 10;
		endcase
	endfunction

	task automatic add_equation();
		int n, kind, kk, rr;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			add_term(pick_coef(), 3'($urandom_range(0, 7)), 1'($urandom), 1);
		end else if (kind == 1) begin
			kk = $urandom_range(1, 8);
			rr = int'($urandom_range(0, 20)) - 10;
			add_term(32'(kk) << 16, 3'd2, 0, 0);
			add_term(32'(-kk * kk * rr * rr) << 16, 3'd0, 1, 0);
			add_term(32'(-2 * kk * rr) << 16, 3'd1, 0, 1);
		end else begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				add_term(pick_coef(),
					kind == 2 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 2)),
					1'($urandom), i == n - 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) solve_term(held);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_axis_tvalid <= 0;
				end else if (pending.size() > 200 && $urandom_range(0, 7) == 0) begin
					src_gap <= $urandom_range(1, 12) - 1;
					s_axis_tvalid <= 0;
				end else if (pending.size() > 0) begin
					held = pending.pop_front();
					s_axis_tvalid <= 1;
					s_axis_tdata <= {4'd0, held.rs, held.expo, held.coef};
					s_axis_tlast <= held.last;
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			dst_gap <= 0;
			hold_cnt <= 0;
			hold_done <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= hold_cnt == 1;
		end else if (!hold_done && results_seen == 20) begin
			hold_done <= 1;
			hold_cnt <= 600;
			m_axis_tready <= 0;
		end else if (dst_gap > 0) begin
			dst_gap <= dst_gap - 1;
			m_axis_tready <= dst_gap == 1;
		end else if (pending.size() > 200 && $urandom_range(0, 5) == 0) begin
			dst_gap <= $urandom_range(1, 12);
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		solution_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (solutions.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, m_axis_tdata);
				errors++;
			end else begin
				e = solutions.pop_front();
				if (m_axis_tdata[2:0] != e.status || m_axis_tdata[5:3] != e.degree ||
						m_axis_tdata[37:6] != e.v1 || m_axis_tdata[69:38] != e.v2 ||
						m_axis_tdata[70] != e.ovf) begin
					$display("%0t: expected st=%0d deg=%0d v1=%h v2=%h ovf=%0d", $realtime,
						e.status, e.degree, e.v1, e.v2, e.ovf);
					$display("%0t: actual   st=%0d deg=%0d v1=%h v2=%h ovf=%0d", $realtime,
						m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6],
						m_axis_tdata[69:38], m_axis_tdata[70]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		sum_ovf = 0;
		foreach (sums[i]) sums[i] = 0;
		arst_n = 0;
		// all X, contradiction, linear, two real, double, complex, high degree
		add_term(0, 3'd0, 0, 1);
		add_term(32'h00050000, 3'd0, 0, 1);
		add_term(32'h00020000, 3'd1, 0, 0);
		add_term(32'h00060000, 3'd0, 1, 1);
		add_term(32'h00010000, 3'd2, 0, 0);
		add_term(32'h00030000, 3'd1, 1, 0);
		add_term(32'h00020000, 3'd0, 0, 1);
		add_term(32'h00010000, 3'd2, 0, 0);
		add_term(32'h00040000, 3'd1, 1, 0);
		add_term(32'h00040000, 3'd0, 0, 1);
		add_term(32'hFFFF0000, 3'd2, 0, 0);
		add_term(32'h00010000, 3'd1, 0, 0);
		add_term(32'h00030000, 3'd0, 1, 1);
		add_term(32'h00010000, 3'd7, 0, 0);
		add_term(32'h00010000, 3'd3, 1, 1);
		// terms cancelling to zero, root saturation, field extremes
		add_term(32'h00010000, 3'd2, 0, 0);
		add_term(32'h00010000, 3'd2, 1, 1);
		add_term(32'h00000001, 3'd1, 0, 0);
		add_term(32'h7FFFFFFF, 3'd0, 0, 1);
		add_term(32'h80000000, 3'd1, 1, 0);
		add_term(32'h80000000, 3'd0, 0, 1);
		add_term(32'hFFFFFFFF, 3'd2, 1, 0);
		add_term(32'h7FFFFFFF, 3'd1, 0, 0);
		add_term(32'h80000000, 3'd0, 1, 1);
		while (pending.size() < 1350) add_equation();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		wait (pending.size() == 0 && !s_axis_tvalid);
		wait (solutions.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && solutions.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

@@ filelist.f @@
src/prs_pkg.sv
src/prs_unit.sv
src/polynomial_reduce_and_solve.sv
tb/polynomial_reduce_and_solve_tb.sv
